// ----- rtl/core/dtp_pkg.sv -----
// Shared types, character codes and helpers for the SQL date/time literal parser.
`timescale 1ns / 1ps

package dtp_pkg;

	localparam int unsigned FRAC_DIGITS_DEF = 6;
	localparam int unsigned US_W            = 20;

	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		KIND_DATE     = 2'd0,
		KIND_TIME     = 2'd1,
		KIND_DATETIME = 2'd2
	} kind_t;

	typedef enum logic [12:0] {
		PH_START   = 13'b0000000000001,
		PH_HOUR0   = 13'b0000000000010,
		PH_HOUR    = 13'b0000000000100,
		PH_MIN     = 13'b0000000001000,
		PH_COL2    = 13'b0000000010000,
		PH_SEC     = 13'b0000000100000,
		PH_SECDONE = 13'b0000001000000,
		PH_FRAC0   = 13'b0000010000000,
		PH_FRAC    = 13'b0000100000000,
		PH_MON     = 13'b0001000000000,
		PH_DASH2   = 13'b0010000000000,
		PH_DAY     = 13'b0100000000000,
		PH_DAYDONE = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic             date;
		logic [3:0]       idx;
		logic [13:0]      lead_val;
		logic [2:0]       lead_cnt;
		logic [9:0]       acc;
		logic [1:0]       fcnt;
		logic [13:0]      year;
		logic [6:0]       month;
		logic [6:0]       day;
		logic [9:0]       hour;
		logic [6:0]       minute;
		logic [6:0]       second;
		logic [US_W-1:0]  frac;
		logic             minus;
		logic             err;
	} dtp_state_t;

	typedef struct packed {
		logic             valid_res;
		kind_t            kind;
		logic             negative;
		logic [13:0]      year;
		logic [6:0]       month;
		logic [6:0]       day;
		logic [9:0]       hour;
		logic [6:0]       minute;
		logic [6:0]       second;
		logic [US_W-1:0]  microsecond;
	} dtp_result_t;

	function automatic dtp_state_t state_reset();
		dtp_state_t r;
		r = '0;
		r.phase = PH_START;
		return r;
	endfunction

	// 10**k, low US_W bits; only evaluated on constants
	function automatic logic [US_W-1:0] pow10_mod(input int unsigned k);
		logic [US_W+3:0] p;
		p = (US_W+4)'(1);
		for (int unsigned i = 0; i < k; i++) begin
			p = (US_W+4)'(p[US_W-1:0] * (US_W+4)'(10));
		end
		return p[US_W-1:0];
	endfunction

endpackage

// ----- rtl/core/sql_datetime_text_parser_core.sv -----
// Top level of the SQL date/time literal parser: input register, state and result register.
`timescale 1ns / 1ps
//
// Usage
//   Characters of a literal arrive on the lit channel (ch, last), one transfer
//   per character; last marks the final character. Each literal gives exactly
//   one transfer on the dt channel, carrying valid_res, kind, negative and the
//   date/time fields. Malformed text gives valid_res=0 with all fields zero.
//   Path: a final character is parsed from the input register by dtp_step and
//   lands in the result register, which drives dt_valid; the result then
//   transfers when dt_stall is low.
//   Throughput: one character per cycle while lit_stall is low, including
//   back-to-back literals; the parse state takes one pass of dtp_step per character.
//   Stall: the result register holds while dt_stall is high. Lit_stall only
//   rises when a final character sits in the input register and the result
//   register still holds an untaken result; ordinary characters keep flowing.
//   Reset (arst_n low): the channels empty and the parse restarts at the
//   first character of a literal.
//

module sql_datetime_text_parser_core #(
	parameter int unsigned FRACTION_DIGITS = dtp_pkg::FRAC_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// character channel
	input  logic        lit_valid,
	output logic        lit_stall,
	input  logic [7:0]  ch,
	input  logic        last,
	// result channel
	output logic        dt_valid,
	input  logic        dt_stall,
	output logic        valid_res,
	output logic [1:0]  kind,
	output logic        negative,
	output logic [13:0] year,
	output logic [6:0]  month,
	output logic [6:0]  day,
	output logic [9:0]  hour,
	output logic [6:0]  minute,
	output logic [6:0]  second,
	output logic [19:0] microsecond
);
	import dtp_pkg::*;

	localparam int unsigned FCW = $clog2(FRACTION_DIGITS + 1);

	// input register
	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// parse state, updated once per character
	dtp_state_t     st_q;
	logic [FCW-1:0] fcount_q;
	dtp_state_t     st_nx;
	logic [FCW-1:0] fcount_nx;
	dtp_result_t    res_nx;

	// result register
	logic        res_vld_q;
	dtp_result_t res_q;

	logic step_go;

	// a character moves on unless it closes a literal and the result slot is blocked
	assign step_go   = vld_s1 && (!last_s1 || !res_vld_q || !dt_stall);
	assign lit_stall = vld_s1 && !step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!lit_stall) begin
			vld_s1 <= lit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (lit_valid && !lit_stall) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	dtp_step #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_step (
		.ch        (ch_s1),
		.last      (last_s1),
		.cur       (st_q),
		.cur_fcount(fcount_q),
		.nx        (st_nx),
		.nx_fcount (fcount_nx),
		.res       (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= state_reset();
			fcount_q <= '0;
		end else if (step_go) begin
			st_q     <= st_nx;
			fcount_q <= fcount_nx;
		end
	end

	// result slot: filled by a closing character, emptied by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (step_go && last_s1) begin
			res_vld_q <= 1'b1;
		end else if (!dt_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && last_s1) begin
			res_q <= res_nx;
		end
	end

	assign dt_valid    = res_vld_q;
	assign valid_res   = res_q.valid_res;
	assign kind        = res_q.kind;
	assign negative    = res_q.negative;
	assign year        = res_q.year;
	assign month       = res_q.month;
	assign day         = res_q.day;
	assign hour        = res_q.hour;
	assign minute      = res_q.minute;
	assign second      = res_q.second;
	assign microsecond = res_q.microsecond;

endmodule

// ----- rtl/core/dtp_step.sv -----
// Per-character next-state and result logic of the date/time literal parser.
`timescale 1ns / 1ps

module dtp_step #(
	parameter int unsigned FRACTION_DIGITS = dtp_pkg::FRAC_DIGITS_DEF,
	localparam int unsigned FCW = $clog2(FRACTION_DIGITS + 1)
) (
	input  logic [7:0]           ch,
	input  logic                 last,
	input  dtp_pkg::dtp_state_t  cur,
	input  logic [FCW-1:0]       cur_fcount,
	output dtp_pkg::dtp_state_t  nx,
	output logic [FCW-1:0]       nx_fcount,
	output dtp_pkg::dtp_result_t res
);
	import dtp_pkg::*;

	localparam int unsigned TAB_N = 2 ** FCW;

	// weight of the fraction digit at each position, padded to full precision
	logic [US_W-1:0] weight_tab [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_wt
		if (g < FRACTION_DIGITS) begin : g_on
			assign weight_tab[g] = pow10_mod(FRACTION_DIGITS - 1 - g);
		end else begin : g_off
			assign weight_tab[g] = '0;
		end
	end

	logic       dig;
	logic [3:0] d;

	assign dig = (ch inside {[CH_ZERO:CH_NINE]});
	assign d   = dig ? ch[3:0] : 4'd0;

	always_comb begin
		phase_t      st_w;
		logic [9:0]  acc_w;
		logic [1:0]  fc_w;
		logic [9:0]  acc_nx;
		logic [1:0]  maxh;
		logic        pre_err;
		logic [US_W-1:0] add_w;

		nx        = cur;
		nx_fcount = cur_fcount;
		res       = '0;
		st_w      = cur.phase;
		acc_w     = cur.acc;
		fc_w      = cur.fcnt;
		pre_err   = 1'b0;
		maxh      = cur.date ? 2'd2 : 2'd3;
		acc_nx    = '0;
		add_w     = '0;

		if (!cur.err) begin
			if (cur.idx < 4'd4 && {1'b0, cur.lead_cnt} == cur.idx && dig) begin
				nx.lead_val = 14'(cur.lead_val * 14'd10 + 14'(d));
				nx.lead_cnt = cur.lead_cnt + 3'd1;
			end else if (cur.idx == 4'd4 && cur.lead_cnt == 3'd4 && ch == CH_DASH) begin
				nx.year  = cur.lead_val;
				nx.acc   = '0;
				nx.fcnt  = '0;
				nx.date  = 1'b1;
				nx.phase = PH_MON;
			end else begin
				// held-back leading digits become the hour of a time
				if (cur.phase == PH_START && cur.lead_cnt != 3'd0) begin
					if (cur.lead_cnt > 3'd3) begin
						pre_err = 1'b1;
					end else begin
						acc_w = cur.lead_val[9:0];
						fc_w  = cur.lead_cnt[1:0];
						st_w  = PH_HOUR;
					end
				end
				acc_nx = 10'(14'(acc_w) * 14'd10 + 14'(d));
				if (pre_err) begin
					nx.err = 1'b1;
				end else begin
					nx.phase = st_w;
					nx.acc   = acc_w;
					nx.fcnt  = fc_w;
					case (st_w)
						PH_START: begin
							if (ch == CH_DASH) begin
								nx.minus = 1'b1;
								nx.phase = PH_HOUR0;
							end else if (dig) begin
								nx.acc   = 10'(d);
								nx.fcnt  = 2'd1;
								nx.phase = PH_HOUR;
							end else begin
								nx.err = 1'b1;
							end
						end
						PH_HOUR0: begin
							if (dig) begin
								nx.acc   = 10'(d);
								nx.fcnt  = 2'd1;
								nx.phase = PH_HOUR;
							end else begin
								nx.err = 1'b1;
							end
						end
						PH_HOUR: begin
							if (dig) begin
								if (fc_w >= maxh) begin
									nx.err = 1'b1;
								end else begin
									nx.acc  = acc_nx;
									nx.fcnt = fc_w + 2'd1;
								end
							end else if (ch == CH_COLON) begin
								nx.hour  = acc_w;
								nx.acc   = '0;
								nx.fcnt  = '0;
								nx.phase = PH_MIN;
							end else begin
								nx.err = 1'b1;
							end
						end
						PH_MIN: begin
							if (!dig) begin
								nx.err = 1'b1;
							end else begin
								nx.acc  = acc_nx;
								nx.fcnt = fc_w + 2'd1;
								if (fc_w >= 2'd1) begin
									nx.minute = acc_nx[6:0];
									nx.phase  = PH_COL2;
								end
							end
						end
						PH_COL2: begin
							if (ch == CH_COLON) begin
								nx.acc   = '0;
								nx.fcnt  = '0;
								nx.phase = PH_SEC;
							end else begin
								nx.err = 1'b1;
							end
						end
						PH_SEC: begin
							if (!dig) begin
								nx.err = 1'b1;
							end else begin
								nx.acc  = acc_nx;
								nx.fcnt = fc_w + 2'd1;
								if (fc_w >= 2'd1) begin
									nx.second = acc_nx[6:0];
									nx.phase  = PH_SECDONE;
								end
							end
						end
						PH_SECDONE: begin
							if (ch == CH_DOT) begin
								nx.phase = PH_FRAC0;
							end else begin
								nx.err = 1'b1;
							end
						end
						PH_FRAC0: begin
							if (dig) begin
								nx.frac   = US_W'((US_W+4)'(d) * (US_W+4)'(weight_tab[0]));
								nx_fcount = FCW'(1);
								nx.phase  = PH_FRAC;
							end else begin
								nx.err = 1'b1;
							end
						end
						PH_FRAC: begin
							if (!dig) begin
								nx.err = 1'b1;
							end else if (cur_fcount < FCW'(FRACTION_DIGITS)) begin
								// digits past the kept precision are checked and dropped
								add_w = US_W'((US_W+4)'(d) * (US_W+4)'(weight_tab[cur_fcount]));
								nx.frac   = cur.frac + add_w;
								nx_fcount = cur_fcount + FCW'(1);
							end
						end
						PH_MON: begin
							if (!dig) begin
								nx.err = 1'b1;
							end else begin
								nx.acc  = acc_nx;
								nx.fcnt = fc_w + 2'd1;
								if (fc_w >= 2'd1) begin
									nx.month = acc_nx[6:0];
									nx.phase = PH_DASH2;
								end
							end
						end
						PH_DASH2: begin
							if (ch == CH_DASH) begin
								nx.acc   = '0;
								nx.fcnt  = '0;
								nx.phase = PH_DAY;
							end else begin
								nx.err = 1'b1;
							end
						end
						PH_DAY: begin
							if (!dig) begin
								nx.err = 1'b1;
							end else begin
								nx.acc  = acc_nx;
								nx.fcnt = fc_w + 2'd1;
								if (fc_w >= 2'd1) begin
									nx.day   = acc_nx[6:0];
									nx.phase = PH_DAYDONE;
								end
							end
						end
						PH_DAYDONE: begin
							if (ch == CH_SPACE || ch == CH_T) begin
								nx.acc   = '0;
								nx.fcnt  = '0;
								nx.phase = PH_HOUR0;
							end else begin
								nx.err = 1'b1;
							end
						end
						default: begin
							nx.err = 1'b1;
						end
					endcase
				end
			end
		end

		if (cur.idx != 4'hF) begin
			nx.idx = cur.idx + 4'd1;
		end

		if (last) begin
			if (!nx.err) begin
				if (nx.date && nx.phase == PH_DAYDONE) begin
					res.valid_res = 1'b1;
					res.kind      = KIND_DATE;
					res.year      = nx.year;
					res.month     = nx.month;
					res.day       = nx.day;
				end else if (nx.phase == PH_SECDONE || nx.phase == PH_FRAC) begin
					res.valid_res = 1'b1;
					res.kind      = nx.date ? KIND_DATETIME : KIND_TIME;
					res.negative  = nx.date ? 1'b0 : nx.minus;
					if (nx.date) begin
						res.year  = nx.year;
						res.month = nx.month;
						res.day   = nx.day;
					end
					res.hour        = nx.hour;
					res.minute      = nx.minute;
					res.second      = nx.second;
					res.microsecond = (nx.phase == PH_FRAC) ? nx.frac : '0;
				end
			end
			nx        = state_reset();
			nx_fcount = '0;
		end
	end

endmodule

// ----- rtl/core/dtp_checker.sv -----
// Port-level assertions for the date/time literal parser, bound to the top level.
`timescale 1ns / 1ps

module dtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        lit_stall,
	input logic        dt_valid,
	input logic        dt_stall,
	input logic        valid_res,
	input logic [1:0]  kind,
	input logic        negative,
	input logic [13:0] year,
	input logic [6:0]  month,
	input logic [6:0]  day,
	input logic [9:0]  hour,
	input logic [6:0]  minute,
	input logic [6:0]  second,
	input logic [19:0] microsecond
);
	import dtp_pkg::*;

	// a held result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dt_valid && dt_stall |=> dt_valid)
		else $error("result dropped while stalled");

	// input backpressure only comes from a blocked result slot
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		lit_stall |-> dt_valid && dt_stall)
		else $error("input stalled without output backpressure");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dt_valid && !valid_res |-> kind == KIND_DATE && !negative && year == 14'd0
			&& month == 7'd0 && day == 7'd0 && hour == 10'd0 && minute == 7'd0
			&& second == 7'd0 && microsecond == 20'd0)
		else $error("malformed literal with nonzero fields");

	a_date_time0: assert property (@(posedge clk) disable iff (!arst_n)
		dt_valid && valid_res && kind == KIND_DATE |-> !negative && hour == 10'd0
			&& minute == 7'd0 && second == 7'd0 && microsecond == 20'd0)
		else $error("date carries time fields");

	a_neg_time: assert property (@(posedge clk) disable iff (!arst_n)
		dt_valid && negative |-> valid_res && kind == KIND_TIME && year == 14'd0)
		else $error("minus outside a time literal");

endmodule

bind sql_datetime_text_parser_core dtp_checker u_dtp_checker (.*);
